// File: rtl/core/lgl_pkg.sv
// ----------------------------------------------------------------------------
// lgl_pkg
// Shared types and constants for the light-gate lap timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lgl_pkg;

	localparam int MAX_LAPS   = 32;
	localparam int LAP_IDX_W  = $clog2(MAX_LAPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] MIN_PULSE_RST = 16'd15;
	localparam logic [15:0] ARM_DELAY_RST = 16'd500;
	localparam logic [7:0]  START_BYTE    = 8'd83;   // 'S'

	// command codes
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_GATE   = 3'd1;
	localparam logic [2:0] CMD_RADIO  = 3'd2;
	localparam logic [2:0] CMD_BUTTON = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_DELAY = 2'd1;

	// reported mode codes
	localparam logic [1:0] MODE_CODE_READY   = 2'd0;
	localparam logic [1:0] MODE_CODE_RUNNING = 2'd1;
	localparam logic [1:0] MODE_CODE_DISPLAY = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic       gate_level;
		logic [7:0] start_char;
		logic [4:0] entry_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] elapsed_ms;
		logic        lap_recorded;
		logic        crossing_rejected;
		logic        lap_full;
		logic [31:0] lap_time_ms;
		logic [5:0]  lap_count;
		logic [31:0] entry_time_ms;
	} out_word_t;

	typedef struct packed {
		logic                 en;
		logic [LAP_IDX_W-1:0] addr;
		logic [31:0]          data;
	} lap_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/lgl_lap_store.sv
// ----------------------------------------------------------------------------
// lgl_lap_store
// Lap time register file: one write port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lgl_lap_store (
	input  wire logic                         clk,
	input  wire lgl_pkg::lap_wr_t             wr,
	input  wire logic [lgl_pkg::LAP_IDX_W-1:0] rd_addr,
	output logic [31:0]                       rd_data
);
	import lgl_pkg::*;

	logic [31:0] laps_q [MAX_LAPS];

	// entries past the fill count are never reported, so no reset
	always_ff @(posedge clk) begin
		if (wr.en) begin
			laps_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = laps_q[rd_addr];

endmodule

`default_nettype wire

// File: rtl/core/lgl_step.sv
// ----------------------------------------------------------------------------
// lgl_step
// Run state and per-word update: mode, ms counter, captures, lap count.
// ----------------------------------------------------------------------------
`default_nettype none

module lgl_step (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire lgl_pkg::in_word_t            item,
	input  wire logic [15:0]                  min_pulse,
	input  wire logic [15:0]                  arm_delay,
	input  wire logic [31:0]                  rd_data,
	output logic [lgl_pkg::LAP_IDX_W-1:0]     rd_addr,
	output lgl_pkg::lap_wr_t                  wr,
	output lgl_pkg::out_word_t                res
);
	import lgl_pkg::*;

	typedef enum logic [2:0] {
		ST_READY   = 3'b001,
		ST_RUNNING = 3'b010,
		ST_DISPLAY = 3'b100
	} run_st_t;

	run_st_t     mode_q, mode_n;
	logic [31:0] elapsed_q, elapsed_n;
	logic [31:0] rise_q, rise_n;
	logic [31:0] fall_q, fall_n;
	logic        rise_seen_q, rise_seen_n;
	logic        fall_seen_q, fall_seen_n;
	logic [5:0]  laps_q, laps_n;
	logic [31:0] diff;
	logic        pulse_ok;
	logic        recorded, rejected, full;
	logic [31:0] lap_time, entry;
	logic [1:0]  mode_code;

	assign rd_addr = item.entry_index[LAP_IDX_W-1:0];

	always_comb begin
		mode_n      = mode_q;
		elapsed_n   = elapsed_q;
		rise_n      = rise_q;
		fall_n      = fall_q;
		rise_seen_n = rise_seen_q;
		fall_seen_n = fall_seen_q;
		laps_n      = laps_q;
		recorded    = 1'b0;
		rejected    = 1'b0;
		full        = 1'b0;
		lap_time    = '0;
		entry       = '0;
		wr.en       = 1'b0;
		wr.addr     = laps_q[LAP_IDX_W-1:0];
		wr.data     = rise_q;
		diff        = '0;
		pulse_ok    = 1'b0;

		unique case (item.cmd) inside
			CMD_TICK: begin
				if (mode_q == ST_RUNNING) begin
					elapsed_n = elapsed_q + 32'd1;
				end
			end
			CMD_GATE: begin
				if (mode_q == ST_RUNNING) begin
					if (item.gate_level) begin
						rise_n      = elapsed_q;
						rise_seen_n = 1'b1;
					end else begin
						fall_n      = elapsed_q;
						fall_seen_n = 1'b1;
					end
					diff     = fall_n - rise_n;
					// negative difference means fall came first
					pulse_ok = !diff[31] && (diff > {16'd0, min_pulse});
					if (rise_seen_n && fall_seen_n) begin
						if (pulse_ok) begin
							if (laps_q < 6'(MAX_LAPS)) begin
								wr.en    = 1'b1;
								wr.data  = rise_n;
								laps_n   = laps_q + 6'd1;
								recorded = 1'b1;
								lap_time = rise_n;
							end else begin
								full = 1'b1;
							end
						end else begin
							rejected = 1'b1;
						end
						rise_n      = '0;
						fall_n      = '0;
						rise_seen_n = 1'b0;
						fall_seen_n = 1'b0;
					end
				end
			end
			CMD_RADIO, CMD_BUTTON: begin
				if (mode_q == ST_READY) begin
					if (item.cmd == CMD_BUTTON || item.start_char == START_BYTE) begin
						elapsed_n   = '0;
						rise_n      = '0;
						fall_n      = '0;
						rise_seen_n = 1'b0;
						fall_seen_n = 1'b0;
						laps_n      = '0;
						mode_n      = ST_RUNNING;
					end
				end else if (item.cmd == CMD_BUTTON) begin
					if (mode_q == ST_RUNNING) begin
						if (elapsed_q > {16'd0, arm_delay}) begin
							mode_n = ST_DISPLAY;
						end
					end else begin
						mode_n = ST_READY;
					end
				end
			end
			CMD_READ: begin
				if ({1'b0, item.entry_index} < laps_q) begin
					entry = rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_READY;
			elapsed_q   <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
			rise_seen_q <= 1'b0;
			fall_seen_q <= 1'b0;
			laps_q      <= '0;
		end else if (adv) begin
			mode_q      <= mode_n;
			elapsed_q   <= elapsed_n;
			rise_q      <= rise_n;
			fall_q      <= fall_n;
			rise_seen_q <= rise_seen_n;
			fall_seen_q <= fall_seen_n;
			laps_q      <= laps_n;
		end
	end

	always_comb begin
		unique case (mode_n)
			ST_READY:   mode_code = MODE_CODE_READY;
			ST_RUNNING: mode_code = MODE_CODE_RUNNING;
			ST_DISPLAY: mode_code = MODE_CODE_DISPLAY;
			default:    mode_code = MODE_CODE_READY;
		endcase
	end

	assign res.mode              = mode_code;
	assign res.elapsed_ms        = elapsed_n;
	assign res.lap_recorded      = recorded;
	assign res.crossing_rejected = rejected;
	assign res.lap_full          = full;
	assign res.lap_time_ms       = lap_time;
	assign res.lap_count         = laps_n;
	assign res.entry_time_ms     = entry;

endmodule

`default_nettype wire

// File: rtl/core/light_gate_lap_timer.sv
// Path: a word is held in the input register, then its result in the result register.
// Throughput: one word per cycle while result_stall is low; the run state updates
//   as a word moves from the input register into the result register.
// Reset (arst_n low, async): ready mode, counter, captures and lap count cleared,
//   config back to min pulse 15 ms and arm delay 500 ms. Lap store is not cleared.
// ----------------------------------------------------------------------------
// light_gate_lap_timer
// Light-gate lap timer: ready / running / display, ms counter, gate-pulse
// qualification and a 32-entry lap store readable by index.
// ----------------------------------------------------------------------------
`default_nettype none

module light_gate_lap_timer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command words
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire lgl_pkg::in_word_t             item,
	// result words
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output lgl_pkg::out_word_t                 result,
	// config writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lgl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgl_pkg::*;

	// input register
	logic      item_valid_s1;
	in_word_t  item_s1;
	// result register
	logic      res_valid_q;
	out_word_t res_q;
	// config
	logic [15:0] min_pulse_q;
	logic [15:0] arm_delay_q;

	logic                 adv;      // word in s1 moves into the result register
	logic                 res_free; // result register can take a word
	logic [LAP_IDX_W-1:0] rd_addr;
	logic [31:0]          rd_data;
	lap_wr_t              wr;
	out_word_t            res;

	assign res_free   = !res_valid_q || !result_stall;
	assign adv        = item_valid_s1 && res_free;
	// s1 can take a new word when empty or emptying this cycle
	assign item_stall = item_valid_s1 && !res_free;

	assign cfg_ready  = 1'b1;

	// config registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RST;
			arm_delay_q <= ARM_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_PULSE: min_pulse_q <= cfg_data;
				REG_ARM_DELAY: arm_delay_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	lgl_lap_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lgl_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.min_pulse (min_pulse_q),
		.arm_delay (arm_delay_q),
		.rd_data   (rd_data),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire
